[rtl/core/sds_pkg.sv]
// Package for the segment disparity SAD search: constants, types and helpers.
`default_nettype none
package sds_pkg;

  localparam int MAX_ROWS_DEF      = 256;
  localparam int MAX_COLS_DEF      = 256;
  localparam int SEARCH_RADIUS_DEF = 6;
  localparam int LABEL_COUNT_DEF   = 512;

  // signed width for warped positions and offsets
  localparam int PW  = 18;
  localparam int CW  = 48;
  localparam int LW  = 9;
  localparam int DW  = 16;
  localparam int OW  = 34;
  localparam int MW  = 27;

  localparam logic [OW-1:0] NO_MATCH_SAD = 34'd10000000000;

  typedef enum logic [1:0] {
    REG_ROWS     = 2'd0,
    REG_COLS     = 2'd1,
    REG_COL_STEP = 2'd2,
    REG_ROW_STEP = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SFLUSH,
    S_COL,
    S_KRD,
    S_KLAT,
    S_MUL,
    S_SRD,
    S_DRAIN,
    S_CMP
  } state_t;

  typedef struct packed {
    logic                 vld;
    logic [CW-1:0]        ref_px;
    logic signed [PW-1:0] row;
    logic signed [PW-1:0] col;
  } scan_tag_t;

  typedef struct packed {
    logic                 vld;
    logic                 kept;
    logic [CW-1:0]        ref_px;
    logic signed [PW-1:0] nr;
    logic signed [PW-1:0] nc;
  } warp_out_t;

  // round num / 2^sh, halves away from zero
  function automatic logic signed [PW-1:0] round_shift(input logic signed [MW-1:0] num,
                                                      input logic [3:0] sh);
    logic [MW-1:0] mag;
    logic [MW-1:0] q;
    mag = num[MW-1] ? MW'(-num) : MW'(num);
    q   = (mag + (MW'(1) << (sh - 4'd1))) >> sh;
    return num[MW-1] ? -$signed(PW'(q)) : $signed(PW'(q));
  endfunction

endpackage
`default_nettype wire

[rtl/core/sds_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none
module sds_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [W-1:0]      wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [W-1:0]      rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/sds_warp.sv]
// Warp unit: disparity scaling, rounding and image bounds test.
`default_nettype none
module sds_warp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire sds_pkg::scan_tag_t          tag_i,
  input  wire logic signed [sds_pkg::DW-1:0] disp_i,
  input  wire logic signed [7:0]           col_step,
  input  wire logic signed [7:0]           row_step,
  input  wire logic signed [sds_pkg::PW-1:0] rows,
  input  wire logic signed [sds_pkg::PW-1:0] cols,
  output sds_pkg::warp_out_t               warp_o
);
  sds_pkg::scan_tag_t         tag1_r;
  logic signed [23:0]         pc_r;
  logic signed [23:0]         pr_r;
  logic signed [sds_pkg::MW-1:0] pc_e;
  logic signed [sds_pkg::MW-1:0] pr_e;
  logic signed [sds_pkg::MW-1:0] pr3;
  logic signed [sds_pkg::PW-1:0] nc;
  logic signed [sds_pkg::PW-1:0] nr;
  sds_pkg::warp_out_t         warp_nxt;

  always_comb begin
    pc_e = sds_pkg::MW'(pc_r);
    pr_e = sds_pkg::MW'(pr_r);
    pr3  = (pr_e <<< 1) + pr_e;
    nc   = tag1_r.col + sds_pkg::round_shift(pc_e, 4'd8);
    nr   = tag1_r.row + sds_pkg::round_shift(pr3, 4'd9);
    warp_nxt.vld    = tag1_r.vld;
    warp_nxt.kept   = (nc >= 0) && (nc < cols) && (nr >= 0) && (nr < rows);
    warp_nxt.ref_px = tag1_r.ref_px;
    warp_nxt.nr     = nr;
    warp_nxt.nc     = nc;
  end

  always_ff @(posedge clk) begin
    pc_r <= col_step * disp_i;
    pr_r <= row_step * disp_i;
    if (!rst_n) begin
      tag1_r <= '0;
      warp_o <= '0;
    end else begin
      tag1_r <= tag_i;
      warp_o <= warp_nxt;
    end
  end
endmodule
`default_nettype wire

[rtl/core/sds_cell.sv]
// Search cell: one row offset's sample stage and SAD accumulator.
`default_nettype none
module sds_cell #(
  parameter int SW = 34
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    smp_shift,
  input  wire logic [sds_pkg::CW-1:0]  smp_i,
  input  wire logic                    smpv_i,
  input  wire logic                    cap,
  input  wire logic [sds_pkg::CW-1:0]  ref_px,
  input  wire logic                    acc_shift,
  input  wire logic [SW-1:0]           acc_i,
  output logic      [sds_pkg::CW-1:0]  smp_o,
  output logic                         smpv_o,
  output logic      [SW-1:0]           acc_o
);
  logic [15:0] d0, d1, d2;
  logic [17:0] sad;

  always_comb begin
    d0  = (ref_px[47:32] > smp_o[47:32]) ? ref_px[47:32] - smp_o[47:32]
                                         : smp_o[47:32] - ref_px[47:32];
    d1  = (ref_px[31:16] > smp_o[31:16]) ? ref_px[31:16] - smp_o[31:16]
                                         : smp_o[31:16] - ref_px[31:16];
    d2  = (ref_px[15:0] > smp_o[15:0]) ? ref_px[15:0] - smp_o[15:0]
                                       : smp_o[15:0] - ref_px[15:0];
    sad = 18'(d0) + 18'(d1) + 18'(d2);
  end

  always_ff @(posedge clk) begin
    if (smp_shift) begin
      smp_o <= smp_i;
    end
    if (!rst_n) begin
      smpv_o <= 1'b0;
      acc_o  <= '0;
    end else begin
      if (smp_shift) begin
        smpv_o <= smpv_i;
      end
      if (acc_shift) begin
        acc_o <= acc_i;
      end else if (cap && smpv_o) begin
        acc_o <= acc_o + SW'(sad);
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/segment_disparity_sad_search.sv]
// Top level of the segment disparity SAD search block.
// A load transaction stores the next pixel in column-major order.
// An evaluate transaction holds busy high while it scans all rows*cols pixels once,
// then runs one pass per column offset over the kept members, the warped members
// that land inside the image; R is the search radius. A row of 2R+1 cells holds
// one accumulator per row offset. The result appears on the out_ ports with
// out_strobe high for one cycle, in the same cycle that busy drops, and stays until
// the next evaluate overwrites it; the receiver must take it.
`default_nettype none
module segment_disparity_sad_search #(
  parameter int MAX_ROWS      = sds_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS      = sds_pkg::MAX_COLS_DEF,
  parameter int SEARCH_RADIUS = sds_pkg::SEARCH_RADIUS_DEF,
  parameter int LABEL_COUNT   = sds_pkg::LABEL_COUNT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_opcode,
  input  wire logic [15:0]        in_ref_c0,
  input  wire logic [15:0]        in_ref_c1,
  input  wire logic [15:0]        in_ref_c2,
  input  wire logic [15:0]        in_side_c0,
  input  wire logic [15:0]        in_side_c1,
  input  wire logic [15:0]        in_side_c2,
  input  wire logic [8:0]         in_segment_label,
  input  wire logic signed [15:0] in_disparity,
  output logic                    out_strobe,
  output logic                    out_found,
  output logic signed [3:0]       out_best_row_offset,
  output logic signed [3:0]       out_best_col_offset,
  output logic [33:0]             out_best_sad,
  output logic [16:0]             out_member_count,
  output logic [16:0]             out_kept_count,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_wdata
);
  localparam int CAP  = MAX_ROWS * MAX_COLS;
  localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int CNTW = $clog2(CAP + 1);
  localparam int RCW  = $clog2(MAX_ROWS + 1);
  localparam int CCW  = $clog2(MAX_COLS + 1);
  localparam int RIW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CIW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int TW   = RCW + CCW;
  localparam int SW   = AW + 18;
  localparam int BW   = (SW > sds_pkg::OW) ? SW : sds_pkg::OW;
  localparam int NC   = 2 * SEARCH_RADIUS + 1;
  localparam int JW   = $clog2(NC + 1);
  localparam int PW   = sds_pkg::PW;
  localparam int CW   = sds_pkg::CW;
  localparam int KW   = CW + RIW + CIW;

  // configuration
  logic [8:0]        rows_r, cols_r;
  logic signed [7:0] cstep_r, rstep_r;
  logic [RCW-1:0]    eff_rows;
  logic [CCW-1:0]    eff_cols;
  logic [TW-1:0]     total;
  logic signed [PW-1:0] rows_s, cols_s;

  sds_pkg::state_t state_r, state_nxt;

  logic [TW-1:0]  ptr_r;
  logic [TW-1:0]  p_eff, p_inc;
  logic           load_we, eval_go;

  logic [8:0]     lab_r;
  logic           lab_ok_r;
  logic [AW-1:0]  scan_i_r;
  logic [RIW-1:0] scan_row_r;
  logic [CIW-1:0] scan_col_r;
  logic           scan_last;
  logic           rd_v_r;
  logic [RIW-1:0] rd_row_r;
  logic [CIW-1:0] rd_col_r;
  logic [2:0]     fcnt_r;

  logic [CW-1:0]  ref_q, side_q;
  logic [8:0]     lab_q;
  logic [15:0]    disp_q;
  logic [KW-1:0]  kept_q;

  sds_pkg::scan_tag_t tag;
  sds_pkg::warp_out_t warp;
  logic           kept_we;

  logic [CNTW-1:0] member_r, kept_r, p_r;
  logic signed [PW-1:0] oc_r;
  logic [JW-1:0]   j_r;
  logic            dcnt_r;
  logic [CW-1:0]   ref_k_r;
  logic [RIW-1:0]  nr_k_r;
  logic signed [PW-1:0] xc_r;
  logic            colok_r;
  logic [AW-1:0]   colbase_r;
  logic signed [PW-1:0] xr;
  logic            xr_ok;
  logic [AW-1:0]   side_addr;
  logic            shift_d_r, smpv_d_r, last_d_r, cap_r;

  logic [BW-1:0]   best_r;
  logic            found_r;
  logic [3:0]      brow_r, bcol_r;
  logic [SW-1:0]   sum;
  logic signed [PW-1:0] orow;
  logic            better;
  logic            j_last, oc_last;

  logic [CW-1:0]   smp_w  [NC];
  logic            smpv_w [NC];
  logic [SW-1:0]   acc_w  [NC];

  always_comb begin
    if (rows_r == 9'd0) eff_rows = RCW'(1);
    else if (int'(rows_r) > MAX_ROWS) eff_rows = RCW'(MAX_ROWS);
    else eff_rows = RCW'(rows_r);
    if (cols_r == 9'd0) eff_cols = CCW'(1);
    else if (int'(cols_r) > MAX_COLS) eff_cols = CCW'(MAX_COLS);
    else eff_cols = CCW'(cols_r);
    total  = TW'(eff_rows) * TW'(eff_cols);
    rows_s = $signed(PW'(eff_rows));
    cols_s = $signed(PW'(eff_cols));
  end

  assign busy    = (state_r != sds_pkg::S_IDLE);
  assign load_we = start && !busy && !in_opcode;
  assign eval_go = start && !busy && in_opcode;
  assign p_eff   = (ptr_r >= total) ? '0 : ptr_r;
  assign p_inc   = p_eff + TW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r  <= 9'd256;
      cols_r  <= 9'd256;
      cstep_r <= '0;
      rstep_r <= '0;
    end else if (cfg_we) begin
      case (sds_pkg::cfg_reg_t'(cfg_index))
        sds_pkg::REG_ROWS:     rows_r  <= cfg_wdata;
        sds_pkg::REG_COLS:     cols_r  <= cfg_wdata;
        sds_pkg::REG_COL_STEP: cstep_r <= $signed(cfg_wdata[7:0]);
        sds_pkg::REG_ROW_STEP: rstep_r <= $signed(cfg_wdata[7:0]);
        default: ;
      endcase
    end
  end

  // stores
  sds_ram #(.W(CW), .D(CAP)) u_ref_ram (
    .clk(clk), .we(load_we), .waddr(p_eff[AW-1:0]),
    .wdata({in_ref_c0, in_ref_c1, in_ref_c2}), .raddr(scan_i_r), .rdata(ref_q)
  );
  sds_ram #(.W(CW), .D(CAP)) u_side_ram (
    .clk(clk), .we(load_we), .waddr(p_eff[AW-1:0]),
    .wdata({in_side_c0, in_side_c1, in_side_c2}), .raddr(side_addr), .rdata(side_q)
  );
  sds_ram #(.W(9), .D(CAP)) u_label_ram (
    .clk(clk), .we(load_we), .waddr(p_eff[AW-1:0]),
    .wdata(in_segment_label), .raddr(scan_i_r), .rdata(lab_q)
  );
  sds_ram #(.W(16), .D(CAP)) u_disp_ram (
    .clk(clk), .we(load_we), .waddr(p_eff[AW-1:0]),
    .wdata(in_disparity), .raddr(scan_i_r), .rdata(disp_q)
  );
  sds_ram #(.W(KW), .D(CAP)) u_kept_ram (
    .clk(clk), .we(kept_we), .waddr(kept_r[AW-1:0]),
    .wdata({warp.ref_px, warp.nr[RIW-1:0], warp.nc[CIW-1:0]}),
    .raddr(p_r[AW-1:0]), .rdata(kept_q)
  );

  // scan pipeline
  always_comb begin
    tag.vld    = rd_v_r && (lab_q == lab_r) && lab_ok_r;
    tag.ref_px = ref_q;
    tag.row    = $signed(PW'(rd_row_r));
    tag.col    = $signed(PW'(rd_col_r));
  end

  sds_warp u_warp (
    .clk(clk), .rst_n(rst_n), .tag_i(tag), .disp_i($signed(disp_q)),
    .col_step(cstep_r), .row_step(rstep_r), .rows(rows_s), .cols(cols_s), .warp_o(warp)
  );

  assign kept_we   = warp.vld && warp.kept;
  assign scan_last = (int'(scan_i_r) + 1 == int'(total));

  // search addressing
  always_comb begin
    xr = $signed(PW'(nr_k_r)) + $signed(PW'(j_r)) - PW'(SEARCH_RADIUS);
    xr_ok = colok_r && (xr >= 0) && (xr < rows_s);
    side_addr = colbase_r + AW'(xr[RIW-1:0]);
    sum  = acc_w[NC-1];
    orow = $signed(PW'(j_r)) - PW'(SEARCH_RADIUS);
    better = (BW'(sum) < best_r) && (sum != '0);
    j_last = (int'(j_r) == NC - 1);
    oc_last = (oc_r == PW'(SEARCH_RADIUS));
  end

  // cell row
  for (genvar k = 0; k < NC; k++) begin : g_cell
    if (k == 0) begin : g_head
      sds_cell #(.SW(SW)) u_cell (
        .clk(clk), .rst_n(rst_n), .smp_shift(shift_d_r), .smp_i(side_q),
        .smpv_i(smpv_d_r), .cap(cap_r), .ref_px(ref_k_r),
        .acc_shift(state_r == sds_pkg::S_CMP), .acc_i('0),
        .smp_o(smp_w[k]), .smpv_o(smpv_w[k]), .acc_o(acc_w[k])
      );
    end else begin : g_body
      sds_cell #(.SW(SW)) u_cell (
        .clk(clk), .rst_n(rst_n), .smp_shift(shift_d_r), .smp_i(smp_w[k-1]),
        .smpv_i(smpv_w[k-1]), .cap(cap_r), .ref_px(ref_k_r),
        .acc_shift(state_r == sds_pkg::S_CMP), .acc_i(acc_w[k-1]),
        .smp_o(smp_w[k]), .smpv_o(smpv_w[k]), .acc_o(acc_w[k])
      );
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sds_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sds_pkg::S_IDLE:   if (eval_go) state_nxt = sds_pkg::S_SCAN;
      sds_pkg::S_SCAN:   if (scan_last) state_nxt = sds_pkg::S_SFLUSH;
      sds_pkg::S_SFLUSH: if (fcnt_r == 3'd3) state_nxt = sds_pkg::S_COL;
      sds_pkg::S_COL:    state_nxt = (kept_r == '0) ? sds_pkg::S_CMP : sds_pkg::S_KRD;
      sds_pkg::S_KRD:    state_nxt = sds_pkg::S_KLAT;
      sds_pkg::S_KLAT:   state_nxt = sds_pkg::S_MUL;
      sds_pkg::S_MUL:    state_nxt = sds_pkg::S_SRD;
      sds_pkg::S_SRD: begin
        if (j_last) begin
          state_nxt = (p_r + CNTW'(1) == kept_r) ? sds_pkg::S_DRAIN : sds_pkg::S_KRD;
        end
      end
      sds_pkg::S_DRAIN:  if (dcnt_r) state_nxt = sds_pkg::S_CMP;
      sds_pkg::S_CMP: begin
        if (j_last) state_nxt = oc_last ? sds_pkg::S_IDLE : sds_pkg::S_COL;
      end
      default: state_nxt = sds_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      rd_v_r     <= 1'b0;
      shift_d_r  <= 1'b0;
      smpv_d_r   <= 1'b0;
      last_d_r   <= 1'b0;
      cap_r      <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      if (load_we) begin
        ptr_r <= (p_inc >= total) ? '0 : p_inc;
      end
      rd_v_r     <= (state_r == sds_pkg::S_SCAN);
      shift_d_r  <= (state_r == sds_pkg::S_SRD);
      smpv_d_r   <= (state_r == sds_pkg::S_SRD) && xr_ok;
      last_d_r   <= (state_r == sds_pkg::S_SRD) && j_last;
      cap_r      <= last_d_r;
      out_strobe <= (state_r == sds_pkg::S_CMP) && j_last && oc_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_row_r <= scan_row_r;
    rd_col_r <= scan_col_r;
    if (kept_we) kept_r <= kept_r + CNTW'(1);
    if (tag.vld) member_r <= member_r + CNTW'(1);
    case (state_r)
      sds_pkg::S_IDLE: begin
        if (eval_go) begin
          lab_r      <= in_segment_label;
          lab_ok_r   <= (int'(in_segment_label) < LABEL_COUNT);
          scan_i_r   <= '0;
          scan_row_r <= '0;
          scan_col_r <= '0;
          member_r   <= '0;
          kept_r     <= '0;
          best_r     <= BW'(sds_pkg::NO_MATCH_SAD);
          found_r    <= 1'b0;
          brow_r     <= '0;
          bcol_r     <= '0;
          oc_r       <= -PW'(SEARCH_RADIUS);
          fcnt_r     <= '0;
        end
      end
      sds_pkg::S_SCAN: begin
        scan_i_r <= scan_i_r + AW'(1);
        if (int'(scan_row_r) + 1 == int'(eff_rows)) begin
          scan_row_r <= '0;
          scan_col_r <= scan_col_r + CIW'(1);
        end else begin
          scan_row_r <= scan_row_r + RIW'(1);
        end
      end
      sds_pkg::S_SFLUSH: fcnt_r <= fcnt_r + 3'd1;
      sds_pkg::S_COL: begin
        p_r <= '0;
        j_r <= '0;
      end
      sds_pkg::S_KLAT: begin
        ref_k_r <= kept_q[KW-1 -: CW];
        nr_k_r  <= kept_q[RIW+CIW-1 -: RIW];
        xc_r    <= $signed(PW'(kept_q[CIW-1:0])) + oc_r;
        colok_r <= ($signed(PW'(kept_q[CIW-1:0])) + oc_r >= 0) &&
                   ($signed(PW'(kept_q[CIW-1:0])) + oc_r < cols_s);
      end
      sds_pkg::S_MUL: begin
        colbase_r <= AW'(TW'(eff_rows) * TW'(xc_r[CIW-1:0]));
        j_r       <= '0;
      end
      sds_pkg::S_SRD: begin
        j_r <= j_r + JW'(1);
        if (j_last) begin
          p_r    <= p_r + CNTW'(1);
          dcnt_r <= 1'b0;
        end
      end
      sds_pkg::S_DRAIN: begin
        dcnt_r <= 1'b1;
        j_r    <= '0;
      end
      sds_pkg::S_CMP: begin
        j_r <= j_r + JW'(1);
        if (better) begin
          best_r  <= BW'(sum);
          found_r <= 1'b1;
          brow_r  <= orow[3:0];
          bcol_r  <= oc_r[3:0];
        end
        if (j_last) begin
          oc_r <= oc_r + PW'(1);
          out_found           <= better || found_r;
          out_best_row_offset <= better ? $signed(orow[3:0]) : $signed(brow_r);
          out_best_col_offset <= better ? $signed(oc_r[3:0]) : $signed(bcol_r);
          out_best_sad        <= better ? 34'(sum) : best_r[33:0];
          out_member_count    <= 17'(member_r);
          out_kept_count      <= 17'(kept_r);
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire
